/* design/cic_pkg.sv */
// ----------------------------------------------------------------------------
// cic_pkg
// Shared types and codes for the control input conditioner.
// ----------------------------------------------------------------------------
`default_nettype none

package cic_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOUND     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TOGGLE    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_STACKING  = 3'd7;

  localparam logic [1:0] MODE_UNBOUND    = 2'd0;
  localparam logic [1:0] MODE_BUTTON     = 2'd1;
  localparam logic [1:0] MODE_CONTINUOUS = 2'd2;
  localparam logic [1:0] MODE_THRESHOLD  = 2'd3;

  typedef struct packed {
    logic [1:0]         mode;
    logic [7:0]         bound;
    logic               invert;
    logic [14:0]        threshold;
    logic signed [15:0] origin;
    logic               active;
    logic               toggle;
    logic               stacking;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic pre_en;
    logic off_en;
    logic val_en;
    logic post_en;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_idle;
  } sts_t;

endpackage

`default_nettype wire

/* design/cic_cfg.sv */
// ----------------------------------------------------------------------------
// cic_cfg
// Configuration register file, written through the configuration channel.
// ----------------------------------------------------------------------------
`default_nettype none

module cic_cfg (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                wr_en_i,
  input  wire logic [cic_pkg::CFG_IDX_W-1:0]       wr_idx_i,
  input  wire logic [cic_pkg::CFG_DATA_W-1:0]      wr_data_i,
  output cic_pkg::cfg_t                            cfg_o
);

  cic_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_idx_i)
        cic_pkg::REG_MODE:      cfg_d.mode      = wr_data_i[1:0];
        cic_pkg::REG_BOUND:     cfg_d.bound     = wr_data_i[7:0];
        cic_pkg::REG_INVERT:    cfg_d.invert    = wr_data_i[0];
        cic_pkg::REG_THRESHOLD: cfg_d.threshold = wr_data_i[14:0];
        cic_pkg::REG_ORIGIN:    cfg_d.origin    = $signed(wr_data_i[15:0]);
        cic_pkg::REG_ACTIVE:    cfg_d.active    = wr_data_i[0];
        cic_pkg::REG_TOGGLE:    cfg_d.toggle    = wr_data_i[0];
        cic_pkg::REG_STACKING:  cfg_d.stacking  = wr_data_i[0];
        default:                cfg_d           = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{mode:      cic_pkg::MODE_UNBOUND,
                 bound:     8'd0,
                 invert:    1'b0,
                 threshold: 15'd0,
                 origin:    16'sd0,
                 active:    1'b1,
                 toggle:    1'b0,
                 stacking:  1'b0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* design/cic_div.sv */
// ----------------------------------------------------------------------------
// cic_div
// Serial restoring divider: (mag << FRAC_BITS) / den, one quotient bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cic_div #(
  parameter int unsigned FRAC_BITS = 14,
  parameter int unsigned MAG_W     = 18
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [MAG_W-1:0]     mag_i,
  input  wire logic [FRAC_BITS:0]   den_i,
  output logic                      idle_o,
  output logic [MAG_W:0]            quo_o
);

  localparam int unsigned QW   = MAG_W + 1;
  localparam int unsigned NW   = MAG_W + FRAC_BITS;
  localparam int unsigned RW   = FRAC_BITS + 2;
  localparam int unsigned CNTW = $clog2(QW + 1);

  logic [NW-1:0]     num;
  logic [RW-1:0]     rem_q, rem_d, trial;
  logic [QW-1:0]     dq_q, dq_d;
  logic [FRAC_BITS:0] den_q;
  logic [CNTW-1:0]   cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              ge;

  assign num   = {mag_i, {FRAC_BITS{1'b0}}};
  assign trial = {rem_q[RW-2:0], dq_q[QW-1]};
  assign ge    = trial >= RW'(den_q);

  always_comb begin
    rem_d  = rem_q;
    dq_d   = dq_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      rem_d  = RW'(num[NW-1:QW]);
      dq_d   = num[QW-1:0];
      cnt_d  = CNTW'(QW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? trial - RW'(den_q) : trial;
      dq_d  = {dq_q[QW-2:0], ge};
      cnt_d = cnt_q - CNTW'(1);
      if (cnt_q == CNTW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dq_q  <= dq_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign idle_o = !busy_q;
  assign quo_o  = dq_q;

endmodule

`default_nettype wire

/* design/cic_dp.sv */
// ----------------------------------------------------------------------------
// cic_dp
// Datapath: input capture, invert, deadzone, threshold, stacking, toggle latch.
// ----------------------------------------------------------------------------
`default_nettype none

module cic_dp #(
  parameter int unsigned FRAC_BITS = 14
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cic_pkg::cfg_t      cfg_i,
  input  wire cic_pkg::cmd_t      cmd_i,
  output cic_pkg::sts_t           sts_o,
  input  wire logic signed [8:0]  event_axis_i,
  input  wire logic signed [8:0]  event_button_i,
  input  wire logic signed [15:0] raw_axis_i,
  input  wire logic               axis_signed_i,
  input  wire logic               axis_limited_i,
  input  wire logic               button_level_i,
  output logic signed [31:0]      out_value_o,
  output logic                    changed_o
);

  localparam int unsigned MW = ((FRAC_BITS > 16) ? FRAC_BITS : 16) + 2;
  localparam int unsigned QW = MW + 1;
  localparam int unsigned VW = MW + 4;
  localparam int unsigned PW = 16 + FRAC_BITS;

  localparam logic signed [VW-1:0] OneV   = VW'(1) << FRAC_BITS;
  localparam logic signed [VW-1:0] HalfV  = OneV >>> 1;
  localparam logic signed [31:0]   One32  = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [31:0]   Half32 = One32 >>> 1;

  localparam logic [1:0] PH_OFF_IDLE = 2'd0;
  localparam logic [1:0] PH_ON_HELD  = 2'd1;
  localparam logic [1:0] PH_ON_IDLE  = 2'd2;
  localparam logic [1:0] PH_OFF_HELD = 2'd3;

  logic signed [8:0]  ev_axis_q, ev_btn_q;
  logic signed [15:0] raw_q;
  logic               signed_q, limited_q, level_q;

  logic signed [VW-1:0] raw_x, org_x, thr_x, axis_v, btn_v, org2, v_pre;
  logic                 match;
  logic signed [VW-1:0] v_q, org2_q;
  logic                 match_q;

  logic signed [VW-1:0] off, mag_full, den_s, den_v;
  logic [MW-1:0]        mag, thr_m, msub;
  logic                 dead, now;
  logic                 off_neg_q, dead_q, now_q;

  logic [QW-1:0]        quo;
  logic                 div_idle;
  logic signed [VW-1:0] q_x, sq, cont, base_v;
  logic                 early_d;
  logic signed [31:0]   base_q;
  logic                 early_q;

  logic                 thr_lvl_q;
  logic [1:0]           phase_q, phase_s, ph_n;
  logic [15:0]          press_q, cnt_n;
  logic                 d1, d2, inc, ovf, tsupp, chg;
  logic [PW-1:0]        prod;
  logic signed [31:0]   stack_v, sv, val;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      ev_axis_q <= event_axis_i;
      ev_btn_q  <= event_button_i;
      raw_q     <= raw_axis_i;
      signed_q  <= axis_signed_i;
      limited_q <= axis_limited_i;
      level_q   <= button_level_i;
    end
  end

  assign raw_x = VW'(raw_q);
  assign org_x = VW'(cfg_i.origin);
  assign thr_x = VW'(cfg_i.threshold);

  always_comb begin
    if (!cfg_i.invert) begin
      axis_v = raw_x;
      org2   = org_x;
    end else begin
      axis_v = (signed_q || !limited_q) ? -raw_x : OneV - raw_x;
      org2   = signed_q ? -org_x : OneV - org_x;
    end
    btn_v = (level_q == cfg_i.active) ? OneV : '0;
    case (cfg_i.mode)
      cic_pkg::MODE_BUTTON: begin
        match = !ev_btn_q[8] && (ev_btn_q[7:0] == cfg_i.bound);
        v_pre = btn_v;
      end
      cic_pkg::MODE_CONTINUOUS, cic_pkg::MODE_THRESHOLD: begin
        match = !ev_axis_q[8] && (ev_axis_q[7:0] == cfg_i.bound);
        v_pre = axis_v;
      end
      default: begin
        match = 1'b0;
        v_pre = axis_v;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pre_en) begin
      v_q     <= v_pre;
      org2_q  <= org2;
      match_q <= match;
    end
  end

  assign off      = v_q - org_x;
  assign mag_full = off[VW-1] ? -off : off;
  assign mag      = mag_full[MW-1:0];
  assign thr_m    = MW'(cfg_i.threshold);
  assign dead     = mag < thr_m;
  assign msub     = mag - thr_m;
  assign den_s    = OneV - thr_x;
  assign den_v    = (den_s < HalfV) ? HalfV : den_s;
  assign now      = v_q > thr_x;

  assign sts_o.need_div = (cfg_i.mode == cic_pkg::MODE_CONTINUOUS) && match_q && !dead;
  assign sts_o.div_idle = div_idle;

  always_ff @(posedge clk_i) begin
    if (cmd_i.off_en) begin
      off_neg_q <= off[VW-1];
      dead_q    <= dead;
      now_q     <= now;
    end
  end

  cic_div #(
    .FRAC_BITS (FRAC_BITS),
    .MAG_W     (MW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.off_en && sts_o.need_div),
    .mag_i   (msub),
    .den_i   (den_v[FRAC_BITS:0]),
    .idle_o  (div_idle),
    .quo_o   (quo)
  );

  assign q_x  = VW'(quo);
  assign sq   = off_neg_q ? -q_x : q_x;
  assign cont = (dead_q ? org_x : org_x + sq) - org2_q;

  always_comb begin
    case (cfg_i.mode)
      cic_pkg::MODE_THRESHOLD:  base_v = now_q ? OneV : '0;
      cic_pkg::MODE_CONTINUOUS: base_v = cont;
      default:                  base_v = v_q;
    endcase
    early_d = !match_q ||
              ((cfg_i.mode == cic_pkg::MODE_THRESHOLD) && (now_q == thr_lvl_q));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.val_en) begin
      base_q  <= 32'(base_v);
      early_q <= early_d;
    end
  end

  assign d1      = base_q > Half32;
  assign inc     = (phase_q == PH_OFF_IDLE) && d1 && (press_q != 16'hFFFF);
  assign cnt_n   = cfg_i.stacking ? press_q + 16'(inc) : press_q;
  assign phase_s = cfg_i.stacking ? {1'b0, d1} : phase_q;
  assign prod    = {cnt_n, {FRAC_BITS{1'b0}}};
  assign ovf     = |(prod >> 31);
  assign stack_v = ovf ? 32'sh7FFF_FFFF : 32'(prod);
  assign sv      = cfg_i.stacking ? stack_v : base_q;
  assign d2      = sv > Half32;

  always_comb begin
    ph_n  = phase_s;
    val   = sv;
    tsupp = 1'b0;
    if (cfg_i.toggle) begin
      case (phase_s)
        PH_OFF_IDLE: begin
          val  = d2 ? One32 : '0;
          ph_n = d2 ? PH_ON_HELD : PH_OFF_IDLE;
        end
        PH_ON_HELD: begin
          tsupp = 1'b1;
          ph_n  = d2 ? PH_ON_HELD : PH_ON_IDLE;
        end
        PH_ON_IDLE: begin
          val  = d2 ? '0 : One32;
          ph_n = d2 ? PH_OFF_HELD : PH_ON_IDLE;
        end
        default: begin
          tsupp = 1'b1;
          ph_n  = d2 ? PH_OFF_HELD : PH_OFF_IDLE;
        end
      endcase
    end
    chg = !early_q && !tsupp;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_lvl_q <= 1'b0;
      press_q   <= '0;
      phase_q   <= PH_OFF_IDLE;
    end else if (cmd_i.post_en && !early_q) begin
      if (cfg_i.mode == cic_pkg::MODE_THRESHOLD) begin
        thr_lvl_q <= now_q;
      end
      press_q <= cnt_n;
      phase_q <= ph_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_value_o <= '0;
      changed_o   <= 1'b0;
    end else if (cmd_i.post_en) begin
      out_value_o <= chg ? val : '0;
      changed_o   <= chg;
    end
  end

endmodule

`default_nettype wire

/* design/cic_ctrl.sv */
// ----------------------------------------------------------------------------
// cic_ctrl
// Sequencer: steps one event through the datapath and owns the handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module cic_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  input  wire cic_pkg::sts_t sts_i,
  output cic_pkg::cmd_t      cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PRE  = 3'd1;
  localparam logic [2:0] ST_OFF  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_VAL  = 3'd4;
  localparam logic [2:0] ST_POST = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_PRE;
        end
      end
      ST_PRE: begin
        cmd_o.pre_en = 1'b1;
        state_d      = ST_OFF;
      end
      ST_OFF: begin
        cmd_o.off_en = 1'b1;
        state_d      = sts_i.need_div ? ST_DIV : ST_VAL;
      end
      ST_DIV: begin
        if (sts_i.div_idle) begin
          state_d = ST_VAL;
        end
      end
      ST_VAL: begin
        cmd_o.val_en = 1'b1;
        state_d      = ST_POST;
      end
      ST_POST: begin
        if (out_free) begin
          cmd_o.post_en = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    out_valid_d = cmd_o.post_en ? 1'b1 : (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

/* design/control_input_conditioner_top.sv */
// ----------------------------------------------------------------------------
// control_input_conditioner_top
// Conditions controller events for one binding: button, axis deadzone and
// threshold, press counting and toggle latch, in Q.FRAC_BITS fixed point.
// Steps: capture the event, pre-stage (invert, binding match), offset and
//   deadzone, the serial divider for matched continuous-mode events outside
//   the deadzone (MAG_W = max(FRAC_BITS, 16) + 2), then value and output.
// Events: one at a time; a new event is taken only once the last result
//   is written to the output register. The output register holds a result
//   while the next runs.
// Reset: asynchronous, active low; registers to defaults, counters cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module control_input_conditioner_top #(
  parameter int unsigned FRAC_BITS = 14
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [cic_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [cic_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic signed [8:0]                  event_axis_i,
  input  wire logic signed [8:0]                  event_button_i,
  input  wire logic signed [15:0]                 raw_axis_i,
  input  wire logic                               axis_signed_i,
  input  wire logic                               axis_limited_i,
  input  wire logic                               button_level_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic signed [31:0]                      out_value_o,
  output logic                                    changed_o
);

  cic_pkg::cfg_t cfg;
  cic_pkg::cmd_t cmd;
  cic_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  cic_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i && cfg_ready_o),
    .wr_idx_i  (cfg_index_i),
    .wr_data_i (cfg_data_i),
    .cfg_o     (cfg)
  );

  cic_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  cic_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .event_axis_i   (event_axis_i),
    .event_button_i (event_button_i),
    .raw_axis_i     (raw_axis_i),
    .axis_signed_i  (axis_signed_i),
    .axis_limited_i (axis_limited_i),
    .button_level_i (button_level_i),
    .out_value_o    (out_value_o),
    .changed_o      (changed_o)
  );

endmodule

`default_nettype wire
